/* hdl/mt19937_word_generator_defines.svh */
// Assertion macros shared by the generator modules.
`ifndef MT19937_WORD_GENERATOR_DEFINES_SVH
`define MT19937_WORD_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/mtwg_pkg.sv */
package mtwg_pkg;

	localparam int STATE_WORDS_DEF  = 624;
	localparam int SHIFT_OFFSET_DEF = 397;

	localparam logic [31:0] TWIST_MATRIX  = 32'h9908_B0DF;
	localparam logic [31:0] HIGH_BIT_MASK = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS_MASK = 32'h7FFF_FFFF;
	localparam logic [31:0] TEMPER_B      = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C      = 32'hEFC6_0000;
	localparam logic [31:0] SEED_MULT     = 32'd1812433253;

	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	typedef struct packed {
		logic seed_start;
		logic seed_mul;
		logic seed_add;
		logic draw_rd;
		logic draw_wb;
	} cmd_t;

	typedef struct packed {
		logic seed_last;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] twist_mix(input logic [31:0] cur, input logic [31:0] nxt);
		logic [31:0] y;
		y = (cur & HIGH_BIT_MASK) | (nxt & LOW_BITS_MASK);
		return (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] x;
		x = w;
		x = x ^ (x >> 11);
		x = x ^ ((x << 7) & TEMPER_B);
		x = x ^ ((x << 15) & TEMPER_C);
		x = x ^ (x >> 18);
		return x;
	endfunction

endpackage

/* hdl/mtwg_ctrl.sv */
`include "mt19937_word_generator_defines.svh"

module mtwg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             action,
	output logic             in_ready,
	output mtwg_pkg::cmd_t   cmd,
	input  mtwg_pkg::sts_t   sts
);

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_SEED_MUL = 4'b0010,
		ST_SEED_ADD = 4'b0100,
		ST_DRAW_WB  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action == mtwg_pkg::ACT_DRAW) begin
						cmd.draw_rd = 1'b1;
						state_d     = ST_DRAW_WB;
					end else begin
						cmd.seed_start = 1'b1;
						state_d        = ST_SEED_MUL;
					end
				end
			end
			ST_SEED_MUL: begin
				cmd.seed_mul = 1'b1;
				state_d      = ST_SEED_ADD;
			end
			ST_SEED_ADD: begin
				cmd.seed_add = 1'b1;
				state_d      = sts.seed_last ? ST_IDLE : ST_SEED_MUL;
			end
			ST_DRAW_WB: begin
				if (sts.out_free) begin
					cmd.draw_wb = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_draw_to_wb, clk, arst_n, in_valid && in_ready && (action == mtwg_pkg::ACT_DRAW), state_q == ST_DRAW_WB)
	`ASSERT_NEXT(a_seed_done, clk, arst_n, (state_q == ST_SEED_ADD) && sts.seed_last, state_q == ST_IDLE)
	`ASSERT_IMPL(a_wb_needs_slot, clk, arst_n, cmd.draw_wb, sts.out_free)

endmodule

/* hdl/mtwg_dp.sv */
`include "mt19937_word_generator_defines.svh"

module mtwg_dp #(
	parameter int STATE_WORDS  = mtwg_pkg::STATE_WORDS_DEF,
	parameter int SHIFT_OFFSET = mtwg_pkg::SHIFT_OFFSET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mtwg_pkg::cmd_t   cmd,
	output mtwg_pkg::sts_t   sts,
	input  logic [31:0]      seed_value,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [31:0]      random_word
);

	localparam int AW = $clog2(STATE_WORDS);

	logic [31:0] mem [STATE_WORDS];

	logic [AW-1:0] p_q, idx_q;
	logic          seeded_q, out_valid_q;
	logic [31:0]   prev_q, prod_s1, cur_q, nxt_q, far_q, word_q;

	logic [AW:0]   p_inc, far_sum;
	logic [AW-1:0] rd_next, rd_far;
	logic [31:0]   seed_word, new_word;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;

	assign p_inc   = {1'b0, p_q} + (AW+1)'(1);
	assign rd_next = (p_inc == (AW+1)'(STATE_WORDS)) ? '0 : p_inc[AW-1:0];
	assign far_sum = {1'b0, p_q} + (AW+1)'(SHIFT_OFFSET);
	assign rd_far  = (far_sum >= (AW+1)'(STATE_WORDS)) ?
		AW'(far_sum - (AW+1)'(STATE_WORDS)) : far_sum[AW-1:0];

	assign seed_word = prod_s1 + 32'(idx_q);
	assign new_word  = far_q ^ mtwg_pkg::twist_mix(cur_q, nxt_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = p_q;
		mem_wdata = new_word;
		if (cmd.seed_start) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = seed_value;
		end else if (cmd.seed_add) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q;
			mem_wdata = seed_word;
		end else if (cmd.draw_wb && seeded_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.draw_rd) begin
			nxt_q <= mem[rd_next];
			far_q <= mem[rd_far];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_start) begin
			prev_q <= seed_value;
			cur_q  <= seed_value;
		end else if (cmd.seed_add) begin
			prev_q <= seed_word;
		end else if (cmd.draw_wb) begin
			cur_q <= nxt_q;
		end
		if (cmd.seed_mul) begin
			prod_s1 <= mtwg_pkg::SEED_MULT * (prev_q ^ (prev_q >> 30));
		end
		if (cmd.draw_wb) begin
			word_q <= seeded_q ? mtwg_pkg::temper(new_word) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q         <= '0;
			idx_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_start) begin
				p_q      <= '0;
				idx_q    <= AW'(1);
				seeded_q <= 1'b1;
			end else if (cmd.seed_add) begin
				idx_q <= AW'({1'b0, idx_q} + (AW+1)'(1));
			end else if (cmd.draw_wb) begin
				p_q <= rd_next;
			end
			if (cmd.draw_wb) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.seed_last = (idx_q == AW'(STATE_WORDS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign random_word   = word_q;

	`ASSERT_IMPL(a_rd_addr_apart, clk, arst_n, cmd.draw_rd, (rd_next != p_q) && (rd_far != p_q))
	`ASSERT_NEXT(a_wb_loads_out, clk, arst_n, cmd.draw_wb, out_valid_q)
	`ASSERT_IMPL(a_seed_idx_range, clk, arst_n, cmd.seed_add, (idx_q != '0) && (idx_q < AW'(STATE_WORDS)))

endmodule

/* hdl/mt19937_word_generator.sv */
// MT19937 32-bit word generator.
// Input channel (in_valid/in_ready): action 0 reseeds from seed_value and
// produces nothing; action 1 draws one tempered word. in_ready is high
// whenever the controller is idle, even while a result waits on the output.
// Output channel (out_valid/out_ready): one random_word per draw, held in an
// output register until its transfer.
// Draw: a read at the input transfer, then twist, write-back and tempering;
// no request is taken before the write-back. The word is visible the cycle
// after it. The pool is twisted one word per draw, with one write and two
// read ports on the pool memory; the word at the read position is registered.
// Reseed: pool word 0 from seed_value, then each further word by a multiply
// step and an add-and-write step on one 32x32 multiplier and adder.
// A draw that finds the output register full waits until out_ready; the input
// side then stalls after at most that one item.
// Reset: read position zero, output empty. The pool memory is not cleared;
// draws before the first reseed return zero and write nothing back.
module mt19937_word_generator #(
	parameter int STATE_WORDS  = mtwg_pkg::STATE_WORDS_DEF,
	parameter int SHIFT_OFFSET = mtwg_pkg::SHIFT_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);

	mtwg_pkg::cmd_t cmd;
	mtwg_pkg::sts_t sts;

	mtwg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mtwg_dp #(
		.STATE_WORDS  (STATE_WORDS),
		.SHIFT_OFFSET (SHIFT_OFFSET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.seed_value  (seed_value),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.random_word (random_word)
	);

endmodule
